@@ hw/rtl/rlct_pkg.sv @@
// ----------------------------------------------------------------------------
// rlct_pkg
// Types, constants and helpers for the rgbc lux and color temperature unit.
// ----------------------------------------------------------------------------
package rlct_pkg;

    // divider geometry
    localparam int NUM_W   = 60;
    localparam int DEN_W   = 28;
    localparam int QUO_W   = 32;
    localparam int DIV_LAT = QUO_W + 1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GAIN  = 2'd0,
        CFG_ATTEN = 2'd1,
        CFG_ITIME = 2'd2
    } t_cfg_idx;

    // reset values of the registers
    localparam logic [15:0] GAIN_RST  = 16'd256;
    localparam logic [15:0] ATTEN_RST = 16'd256;
    localparam logic [7:0]  ITIME_RST = 8'd246;

    // saturation levels of the clear channel
    localparam logic [16:0] LVL_STEP  = 17'd768;
    localparam logic [16:0] LVL_63    = 17'd64512;
    localparam logic [16:0] LVL_FULL  = 17'd65535;
    localparam logic [8:0]  N_RIPPLE  = 9'd62;
    localparam logic [8:0]  N_EDGE    = 9'd63;

    // weighting constants, scaled to integers
    localparam logic signed [30:0] K_R     = 31'sd136;
    localparam logic signed [30:0] K_G     = 31'sd1000;
    localparam logic signed [30:0] K_B     = 31'sd444;
    localparam logic signed [40:0] K_CT_B  = 41'sd975360;
    localparam logic signed [40:0] K_CT_R  = 41'sd356096;
    localparam logic signed [48:0] K_SP_B  = 49'sd487680000;
    localparam logic signed [48:0] K_SP_C  = 49'sd356096;
    localparam logic [4:0]         K_DEN   = 5'd15;
    localparam logic [8:0]         K_ATT   = 9'd248;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
        logic [15:0] clear_count;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] lux_value;
        logic signed [31:0] color_temperature;
        logic               sample_valid;
    } t_out_item;

    // side information that rides along the divider
    typedef struct packed {
        logic               inv;
        logic               lux_neg;
        logic               ct_neg;
        logic               gain_zero;
        logic               red_zero;
        logic signed [31:0] lux_sp;
        logic signed [31:0] ct_sp;
    } t_side;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
        if (v > 49'(S32_MAX)) return S32_MAX;
        if (v < 49'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    // apply sign to a quotient magnitude with clamping
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic ovf,
                                                   input logic [31:0] q);
        if (!neg) begin
            if (ovf || q[31]) return S32_MAX;
            return q;
        end
        if (ovf || q > 32'h8000_0000) return S32_MIN;
        return -q;
    endfunction

endpackage

@@ hw/rtl/rgbc_lux_and_color_temperature_unit.sv @@
// ----------------------------------------------------------------------------
// rgbc_lux_and_color_temperature_unit
// Lux and correlated color temperature from one rgbc reading per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid/o_in_ready  | i_in_item (t_in_item)
//  out     | output    | o_out_valid/i_out_ready| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// one item enters per cycle while the output is not stalled; each result passes four arithmetic
// stages, the 33-stage divider and the output register.
// reset clears the valid bits and loads the register defaults.
// a stalled output freezes the whole pipeline; no item is lost or repeated.
// cfg writes are always taken.
// ----------------------------------------------------------------------------
module rgbc_lux_and_color_temperature_unit import rlct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        en;
    logic [15:0] r_gain;
    logic [15:0] r_atten;
    logic [7:0]  r_itime;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_atten <= ATTEN_RST;
            r_itime <= ITIME_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN:  r_gain  <= i_cfg_data;
                CFG_ATTEN: r_atten <= i_cfg_data;
                CFG_ITIME: r_itime <= i_cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    // stage 1: saturation check and ir removal
    logic [8:0]         n_cyc;
    logic [16:0]        lvl;
    logic [17:0]        sum3;
    logic signed [18:0] ir2;
    logic               r_s1_valid, r_s1_inv;
    logic signed [18:0] r_s1_r2, r_s1_g2, r_s1_b2;

    assign n_cyc = 9'd256 - 9'(r_itime);
    assign lvl   = (n_cyc <= N_RIPPLE) ? 17'(LVL_STEP * 17'(n_cyc)) :
                   (n_cyc == N_EDGE) ? LVL_63 : LVL_FULL;
    assign sum3  = 18'(i_in_item.red_count) + 18'(i_in_item.green_count)
                 + 18'(i_in_item.blue_count);
    assign ir2   = (sum3 > 18'(i_in_item.clear_count))
                 ? $signed({1'b0, sum3 - 18'(i_in_item.clear_count)}) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_inv <= 17'(i_in_item.clear_count) >= lvl;
            r_s1_r2  <= $signed({2'b0, i_in_item.red_count, 1'b0}) - ir2;
            r_s1_g2  <= $signed({2'b0, i_in_item.green_count, 1'b0}) - ir2;
            r_s1_b2  <= $signed({2'b0, i_in_item.blue_count, 1'b0}) - ir2;
        end
    end

    // stage 2: weighted sums and divisors
    logic               r_s2_valid, r_s2_inv, r_s2_gz;
    logic signed [30:0] r_s2_numg;
    logic signed [40:0] r_s2_ctnum;
    logic signed [48:0] r_s2_ctsp;
    logic [DEN_W-1:0]   r_s2_denl;
    logic signed [18:0] r_s2_r2;
    logic [23:0]        r_s2_att;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_inv   <= r_s1_inv;
            r_s2_gz    <= (r_gain == '0);
            r_s2_numg  <= K_R * 31'(r_s1_r2) + K_G * 31'(r_s1_g2) - K_B * 31'(r_s1_b2);
            r_s2_ctnum <= K_CT_B * 41'(r_s1_b2) + K_CT_R * 41'(r_s1_r2);
            r_s2_ctsp  <= K_SP_B * 49'(r_s1_b2) + K_SP_C;
            r_s2_denl  <= DEN_W'(K_DEN * 9'(n_cyc) * DEN_W'(r_gain));
            r_s2_r2    <= r_s1_r2;
            r_s2_att   <= 24'(K_ATT * 24'(r_atten));
        end
    end

    // stage 3: lux numerator product
    logic               r_s3_valid, r_s3_inv, r_s3_gz;
    logic signed [55:0] r_s3_prod;
    logic signed [37:0] r_s3_lux0;
    logic signed [40:0] r_s3_ctnum;
    logic signed [48:0] r_s3_ctsp;
    logic [DEN_W-1:0]   r_s3_denl;
    logic signed [18:0] r_s3_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_inv   <= r_s2_inv;
            r_s3_gz    <= r_s2_gz;
            r_s3_prod  <= 56'(r_s2_numg) * $signed({32'd0, r_s2_att});
            r_s3_lux0  <= 38'(r_s2_numg) <<< 7;
            r_s3_ctnum <= r_s2_ctnum;
            r_s3_ctsp  <= r_s2_ctsp;
            r_s3_denl  <= r_s2_denl;
            r_s3_r2    <= r_s2_r2;
        end
    end

    // stage 4: magnitudes with rounding offset, special-case results
    logic               r_s4_valid;
    t_side              r_s4_side;
    logic [NUM_W-1:0]   r_s4_lnum, r_s4_cnum;
    logic [DEN_W-1:0]   r_s4_lden, r_s4_cden;
    logic [55:0]        lmag;
    logic [40:0]        cmag;
    logic [18:0]        rmag;

    assign lmag = r_s3_prod[55] ? 56'(-r_s3_prod) : 56'(r_s3_prod);
    assign cmag = r_s3_ctnum[40] ? 41'(-r_s3_ctnum) : 41'(r_s3_ctnum);
    assign rmag = r_s3_r2[18] ? 19'(-r_s3_r2) : 19'(r_s3_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_lnum           <= NUM_W'(lmag) + NUM_W'(r_s3_denl >> 1);
            r_s4_lden           <= r_s3_denl;
            r_s4_cnum           <= NUM_W'(cmag) + NUM_W'(rmag >> 1);
            r_s4_cden           <= DEN_W'(rmag);
            r_s4_side.inv       <= r_s3_inv;
            r_s4_side.lux_neg   <= r_s3_prod[55];
            r_s4_side.ct_neg    <= r_s3_ctnum[40] ^ r_s3_r2[18];
            r_s4_side.gain_zero <= r_s3_gz;
            r_s4_side.red_zero  <= (r_s3_r2 == '0);
            r_s4_side.lux_sp    <= sat49(49'(r_s3_lux0));
            r_s4_side.ct_sp     <= sat49(r_s3_ctsp);
        end
    end

    // dividers for lux and color temperature
    logic [QUO_W-1:0] lquo, cquo;
    logic             lovf, covf;

    rlct_div u_div_lux (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s4_lnum),
        .i_den (r_s4_lden),
        .o_quo (lquo),
        .o_ovf (lovf)
    );

    rlct_div u_div_ct (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s4_cnum),
        .i_den (r_s4_cden),
        .o_quo (cquo),
        .o_ovf (covf)
    );

    // side information delay matching the divider
    logic  r_dv [0:DIV_LAT-1];
    t_side r_sd [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_dv[i] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_s4_valid;
            for (int i = 1; i < DIV_LAT; i++) r_dv[i] <= r_dv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_s4_side;
            for (int i = 1; i < DIV_LAT; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    // final selection and output register
    t_side     sd;
    t_out_item n_out;

    assign sd = r_sd[DIV_LAT-1];

    always_comb begin
        n_out = '0;
        if (!sd.inv) begin
            n_out.sample_valid      = 1'b1;
            n_out.lux_value         = sd.gain_zero ? sd.lux_sp
                                                   : sat_mag(sd.lux_neg, lovf, lquo);
            n_out.color_temperature = sd.red_zero ? sd.ct_sp
                                                  : sat_mag(sd.ct_neg, covf, cquo);
        end
    end

    t_out_item r_out_item;
    logic      r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // invalid results carry zero fields
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.sample_valid |->
            o_out_item.lux_value == '0 && o_out_item.color_temperature == '0)
        else $error("invalid item with nonzero fields");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted item not in stage 1");

    // a stall freezes the pipeline valid bits
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s1_valid) && $stable(r_s4_valid) && $stable(r_out_valid))
        else $error("pipeline moved during stall");

    // the last divider stage feeds the output whenever the pipeline moves
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_dv[DIV_LAT-1] |=> o_out_valid)
        else $error("result dropped at output");

endmodule

@@ hw/rtl/rlct_div.sv @@
// ----------------------------------------------------------------------------
// rlct_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module rlct_div import rlct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf
);

    logic [NUM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    // entry stage: quotient that does not fit in QUO_W bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= i_num >= (NUM_W'(i_den) << QUO_W);
        end
    end

    // one compare and subtract per stage, msb first
    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - 1 - j;
        logic [NUM_W-1:0] sh;
        logic             ge;
        assign sh = NUM_W'(r_den[j]) << K;
        assign ge = r_rem[j] >= sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? r_rem[j] - sh : r_rem[j];
                r_den[j+1] <= r_den[j];
                r_quo[j+1] <= r_quo[j] | (QUO_W'(ge) << K);
                r_ovf[j+1] <= r_ovf[j];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule
